// ===== rtl/core/adaptive_window_velocity_estimator_top_defines.svh =====
// Assertion macros shared by the estimator's checker.
`ifndef ADAPTIVE_WINDOW_VELOCITY_ESTIMATOR_TOP_DEFINES_SVH
`define ADAPTIVE_WINDOW_VELOCITY_ESTIMATOR_TOP_DEFINES_SVH

// same-cycle implication
`define AWVE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AWVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/awve_pkg.sv =====
// Types and constants of the adaptive window velocity estimator.
`timescale 1ns / 1ps
package awve_pkg;
  localparam int POS_W  = 32;
  localparam int VEL_W  = 48;
  localparam int NUM_W  = 46;
  localparam int DEN_W  = 16;
  localparam int DIFF_W = POS_W + 1;
  localparam int MA_W   = 47;
  localparam int MB_W   = 22;
  localparam int MP_W   = MA_W + MB_W;
  localparam int DEV_W  = 56;
  localparam int DIV_W  = 67;
  localparam int NB_W   = 31;
  localparam int RATE_W = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_BAND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd2;

  localparam logic [NB_W-1:0]   NOISE_BAND_RST  = 31'd65536;
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 20'd1000;

  localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef struct packed {
    logic              fit_mode;
    logic [NB_W-1:0]   noise_band;
    logic [RATE_W-1:0] sample_rate;
  } awve_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIN,
    ST_RD,
    ST_GET,
    ST_ACC,
    ST_LIM,
    ST_LIMGET,
    ST_JRD,
    ST_JGET,
    ST_JM1,
    ST_JM2,
    ST_PASS,
    ST_SCALE,
    ST_SCALEGET,
    ST_DIV,
    ST_FINISH
  } awve_state_e;
endpackage

// ===== rtl/core/awve_if.sv =====
// Valid/ready request channels for position samples and velocity results.
`timescale 1ns / 1ps
interface awve_pos_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] position;
  modport source (output valid, output position, input ready);
  modport sink (input valid, input position, output ready);
endinterface

interface awve_vel_if;
  logic              valid;
  logic              ready;
  logic signed [47:0] velocity;
  modport source (output valid, output velocity, input ready);
  modport sink (input valid, input velocity, output ready);
endinterface

// ===== rtl/core/awve_ram.sv =====
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module awve_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/core/awve_mul.sv =====
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module awve_mul (
  input  logic                        clk_i,
  input  logic signed [awve_pkg::MA_W-1:0] a_i,
  input  logic signed [awve_pkg::MB_W-1:0] b_i,
  output logic signed [awve_pkg::MP_W-1:0] p_o
);
  import awve_pkg::*;
  logic signed [MP_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MP_W'(a_i) * MP_W'(b_i);
  end

  assign p_o = p_q;
endmodule

// ===== rtl/core/awve_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module awve_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [awve_pkg::DIV_W-1:0] dividend_i,
  input  logic [awve_pkg::DEN_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [awve_pkg::DIV_W-1:0] quot_o
);
  import awve_pkg::*;
  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   sh;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    sh     = {rem_q, quo_q[DIV_W-1]};
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = CNT_W'(DIV_W);
    end else if (cnt_q != '0) begin
      if (sh >= {1'b0, dvs_q}) begin
        rem_d = DEN_W'(sh - {1'b0, dvs_q});
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = sh[DEN_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

// ===== rtl/core/awve_core.sv =====
// Window-growing sequencer around the sample ring, multiplier and divider.
`timescale 1ns / 1ps
module awve_core #(
  parameter int WINDOW = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  awve_pkg::awve_cfg_t              cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [awve_pkg::POS_W-1:0] in_pos_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [awve_pkg::VEL_W-1:0] out_vel_o
);
  import awve_pkg::*;
  localparam int IW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int AW = CW + 1;

  awve_state_e state_q, state_d;

  logic [IW-1:0]           ptr_q, ptr_d, nptr;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    primed_q, primed_d;
  logic signed [POS_W-1:0] first_q, first_d;
  logic signed [POS_W-1:0] pos_q, pos_d;
  logic [CW-1:0]           i_q, i_d, l_q, l_d, j_q, j_d, off_q, off_d;
  logic [DEN_W-1:0]        tri_q, tri_d, dbest_q, dbest_d, den_q, den_d;
  logic [DEN_W-1:0]        acc_den_q, acc_den_d;
  logic signed [NUM_W-1:0] num_q, num_d, acc_num_q, acc_num_d;
  logic signed [DEV_W-1:0] lim_q, lim_d, d1_q, d1_d, dev;
  logic                    neg_q, neg_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [VEL_W-1:0] vel_q, vel_d;

  logic [AW-1:0]           base, addr_full;
  logic [IW-1:0]           raddr;
  logic [POS_W-1:0]        rdata;
  logic signed [POS_W-1:0] val;
  logic signed [DIFF_W-1:0] diff;
  logic [NUM_W-1:0]        mag;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  prod;
  logic                    ram_we, div_start, div_done;
  logic [DIV_W-1:0]        quot;
  logic [VEL_W-1:0]        sat;

  assign nptr      = (ptr_q == IW'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
  assign base      = AW'(ptr_q) + AW'(WINDOW) - AW'(off_q);
  assign addr_full = (base >= AW'(WINDOW)) ? base - AW'(WINDOW) : base;
  assign raddr     = addr_full[IW-1:0];
  assign val       = (off_q < cnt_q) ? $signed(rdata) : first_q;
  assign diff      = DIFF_W'(pos_q) - DIFF_W'(val);
  assign mag       = acc_num_q[NUM_W-1] ? NUM_W'(-acc_num_q) : NUM_W'(acc_num_q);
  assign dev       = d1_q - DEV_W'(prod);

  awve_ram #(.WIDTH(POS_W), .DEPTH(WINDOW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (nptr),
    .wdata_i (in_pos_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  awve_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  awve_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIV_W'(prod) + DIV_W'(acc_den_q >> 1)),
    .divisor_i  (acc_den_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    if (neg_q) begin
      sat = (|quot[DIV_W-1:VEL_W-1]) ? VEL_MIN : VEL_W'(-quot[VEL_W-1:0]);
    end else begin
      sat = (|quot[DIV_W-1:VEL_W-1]) ? VEL_MAX : quot[VEL_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    primed_d    = primed_q;
    first_d     = first_q;
    pos_d       = pos_q;
    i_d         = i_q;
    l_d         = l_q;
    j_d         = j_q;
    off_d       = off_q;
    tri_d       = tri_q;
    dbest_d     = dbest_q;
    den_d       = den_q;
    num_d       = num_q;
    acc_num_d   = acc_num_q;
    acc_den_d   = acc_den_q;
    lim_d       = lim_q;
    d1_d        = d1_q;
    neg_d       = neg_q;
    vel_d       = vel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    div_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ram_we    = 1'b1;
          pos_d     = in_pos_i;
          ptr_d     = nptr;
          cnt_d     = (cnt_q == CW'(WINDOW)) ? cnt_q : cnt_q + 1'b1;
          i_d       = CW'(1);
          tri_d     = DEN_W'(1);
          dbest_d   = DEN_W'(1);
          acc_num_d = '0;
          acc_den_d = DEN_W'(1);
          if (!primed_q) begin
            first_d  = in_pos_i;
            primed_d = 1'b1;
          end
          state_d = ST_WIN;
        end
      end
      ST_WIN: begin
        if (cfg_i.fit_mode) begin
          num_d = '0;
          l_d   = '0;
          off_d = '0;
          den_d = dbest_q;
        end else begin
          off_d = i_q;
          den_d = DEN_W'(i_q);
        end
        state_d = ST_RD;
      end
      ST_RD: state_d = ST_GET;
      ST_GET: begin
        if (cfg_i.fit_mode) begin
          mul_a   = MA_W'(val);
          mul_b   = MB_W'(i_q) - (MB_W'(l_q) << 1);
          state_d = ST_ACC;
        end else begin
          num_d   = NUM_W'(diff);
          state_d = ST_LIM;
        end
      end
      ST_ACC: begin
        num_d = num_q + NUM_W'(prod);
        if (l_q == i_q) begin
          state_d = ST_LIM;
        end else begin
          l_d     = l_q + 1'b1;
          off_d   = l_q + 1'b1;
          state_d = ST_RD;
        end
      end
      ST_LIM: begin
        mul_a   = MA_W'(cfg_i.noise_band);
        mul_b   = MB_W'(den_q);
        state_d = ST_LIMGET;
      end
      ST_LIMGET: begin
        lim_d = DEV_W'(prod);
        j_d   = CW'(1);
        off_d = CW'(1);
        state_d = (i_q == CW'(1)) ? ST_PASS : ST_JRD;
      end
      ST_JRD: state_d = ST_JGET;
      ST_JGET: begin
        mul_a   = MA_W'(diff);
        mul_b   = MB_W'(den_q);
        state_d = ST_JM1;
      end
      ST_JM1: begin
        d1_d    = DEV_W'(prod);
        mul_a   = MA_W'(num_q);
        mul_b   = MB_W'(j_q);
        state_d = ST_JM2;
      end
      ST_JM2: begin
        if (dev > lim_q || dev < -lim_q) begin
          state_d = ST_SCALE;
        end else if (j_q + 1'b1 == i_q) begin
          state_d = ST_PASS;
        end else begin
          j_d     = j_q + 1'b1;
          off_d   = j_q + 1'b1;
          state_d = ST_JRD;
        end
      end
      ST_PASS: begin
        acc_num_d = num_q;
        acc_den_d = den_q;
        if (i_q == CW'(WINDOW - 1)) begin
          state_d = ST_SCALE;
        end else begin
          i_d     = i_q + 1'b1;
          tri_d   = tri_q + DEN_W'(i_q) + 1'b1;
          dbest_d = dbest_q + tri_q + DEN_W'(i_q) + 1'b1;
          state_d = ST_WIN;
        end
      end
      ST_SCALE: begin
        neg_d   = acc_num_q[NUM_W-1];
        mul_a   = MA_W'(mag);
        mul_b   = MB_W'(cfg_i.sample_rate);
        state_d = ST_SCALEGET;
      end
      ST_SCALEGET: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          vel_d       = $signed(sat);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      cnt_q       <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      primed_q    <= primed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q   <= first_d;
    pos_q     <= pos_d;
    i_q       <= i_d;
    l_q       <= l_d;
    j_q       <= j_d;
    off_q     <= off_d;
    tri_q     <= tri_d;
    dbest_q   <= dbest_d;
    den_q     <= den_d;
    num_q     <= num_d;
    acc_num_q <= acc_num_d;
    acc_den_q <= acc_den_d;
    lim_q     <= lim_d;
    d1_q      <= d1_d;
    neg_q     <= neg_d;
    vel_q     <= vel_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_vel_o   = vel_q;
endmodule

// ===== rtl/core/adaptive_window_velocity_estimator_top.sv =====
// Throughput: one request at a time; the shared multiplier and the serial divider set the pace.
// A finished result waits in the output register while the next request is taken.
// Reset: asynchronous, active low; clears control state and loads the register defaults.
`timescale 1ns / 1ps
module adaptive_window_velocity_estimator_top #(
  parameter int WINDOW = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [awve_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [awve_pkg::CFG_DATA_W-1:0] cfg_data_i,
  awve_pos_if.sink                        pos_in,
  awve_vel_if.source                      vel_out
);
  import awve_pkg::*;

  awve_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIT_MODE:    cfg_d.fit_mode    = cfg_data_i[0];
        CFG_NOISE_BAND:  cfg_d.noise_band  = cfg_data_i[NB_W-1:0];
        CFG_SAMPLE_RATE: cfg_d.sample_rate = cfg_data_i[RATE_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fit_mode    <= 1'b0;
      cfg_q.noise_band  <= NOISE_BAND_RST;
      cfg_q.sample_rate <= SAMPLE_RATE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  awve_core #(.WINDOW(WINDOW)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (pos_in.valid),
    .in_ready_o  (pos_in.ready),
    .in_pos_i    (pos_in.position),
    .out_valid_o (vel_out.valid),
    .out_ready_i (vel_out.ready),
    .out_vel_o   (vel_out.velocity)
  );
endmodule

// ===== rtl/core/awve_chk.sv =====
// Port-level checker for the estimator, bound to the top level.
`timescale 1ns / 1ps
`include "adaptive_window_velocity_estimator_top_defines.svh"
module awve_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [awve_pkg::VEL_W-1:0]     out_vel_i
);
  `AWVE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `AWVE_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_vel_i), "stalled result changed")
  `AWVE_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_i, !in_ready_i, "request taken while busy")
  `AWVE_ASSERT_NOW(a_no_instant_result, $past(in_valid_i && in_ready_i), !$rose(out_valid_i), "result too early")
endmodule

bind adaptive_window_velocity_estimator_top awve_chk u_awve_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pos_in.valid),
  .in_ready_i  (pos_in.ready),
  .out_valid_i (vel_out.valid),
  .out_ready_i (vel_out.ready),
  .out_vel_i   (vel_out.velocity)
);
